/* sv/lav_pkg.sv */
// Shared types, constants and bit-length, rounding and clamping helpers of the look-at view matrix block.
package lav_pkg;

    localparam int AXIS_FRAC_BITS = 30;
    localparam logic signed [63:0] AXIS_ONE = 64'sd1 <<< AXIS_FRAC_BITS;
    localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    typedef logic [31:0] t_w32;
    typedef logic [2:0][63:0] t_v64;
    typedef logic [2:0][31:0] t_v32;

    typedef struct packed {
        t_v32 eye;
        t_v32 vec;
        logic degen;
    } t_side;

    typedef struct packed {
        t_v32 [2:0] axis;
        t_v32       off;
        logic       degen;
    } t_rows;

    // Bit length of an unsigned word, 0 for zero.
    function automatic logic [6:0] bitlen(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) n = 7'(k + 1);
        end
        return n;
    endfunction

    // Shift right by 30, rounding half away from zero.
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic [63:0] u;
        u = v[63] ? (~v + 64'd1) : v;
        u = (u + (64'd1 << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
        return v[63] ? -$signed(u) : $signed(u);
    endfunction

    function automatic logic [31:0] clamp_axis(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > AXIS_ONE) c = AXIS_ONE;
        if (v < -AXIS_ONE) c = -AXIS_ONE;
        return c[31:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > S32_MAX) c = S32_MAX;
        if (v < S32_MIN) c = S32_MIN;
        return c[31:0];
    endfunction

endpackage

/* sv/lav_norm.sv */
// Pipelined vector normalizer: scale, sum of squares, square root, three dividers.
module lav_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  lav_pkg::t_v64 i_vec,
    input  lav_pkg::t_side i_side,
    output logic          o_valid,
    output lav_pkg::t_v32 o_unit,
    output logic          o_zero,
    output lav_pkg::t_side o_side
);
    import lav_pkg::*;

    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
        t_side            side;
    } t_carry;

    // stage A: magnitudes
    logic [2:0][63:0] r_a_mag, n_a_mag;
    logic [2:0]       r_a_neg;
    logic [63:0]      r_a_or;
    t_side            r_a_side;
    logic             r_a_v;
    // stage B: bit length
    logic [2:0][63:0] r_b_mag;
    logic [2:0]       r_b_neg;
    logic [6:0]       r_b_len;
    logic             r_b_zero;
    t_side            r_b_side;
    logic             r_b_v;
    // stage C: scaled, D: squares, E: sum
    t_carry           r_c_c, n_c_c, r_d_c, r_e_c;
    logic [2:0][59:0] r_d_sq;
    logic [61:0]      r_e_sum;
    logic             r_c_v, r_d_v, r_e_v;
    // square root steps
    logic [61:0]      r_s_n [SQ_STEPS];
    logic [61:0]      r_s_r [SQ_STEPS];
    t_carry           r_s_c [SQ_STEPS];
    logic             r_s_v [SQ_STEPS];
    logic [61:0]      n_s_n [SQ_STEPS];
    logic [61:0]      n_s_r [SQ_STEPS];
    // divider setup and steps
    logic [2:0][61:0] r_p_rem;
    logic [30:0]      r_p_den;
    t_carry           r_p_c;
    logic             r_p_v;
    logic [2:0][61:0] r_q_rem [DIV_STEPS];
    logic [2:0][31:0] r_q_q   [DIV_STEPS];
    logic [30:0]      r_q_den [DIV_STEPS];
    t_carry           r_q_c   [DIV_STEPS];
    logic             r_q_v   [DIV_STEPS];
    logic [2:0][61:0] n_q_rem [DIV_STEPS];
    logic [2:0][31:0] n_q_q   [DIV_STEPS];
    // output
    t_v32             r_o_unit, n_o_unit;
    logic             r_o_zero;
    t_side            r_o_side;
    logic             r_o_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = i_vec[i][63] ? (~i_vec[i] + 64'd1) : i_vec[i];
        end
    end

    always_comb begin
        n_c_c.neg  = r_b_neg;
        n_c_c.zero = r_b_zero;
        n_c_c.side = r_b_side;
        for (int i = 0; i < 3; i++) begin
            if (r_b_len > 7'd30) begin
                n_c_c.m[i] = 30'(r_b_mag[i] >> (r_b_len - 7'd30));
            end else begin
                n_c_c.m[i] = 30'(r_b_mag[i] << (7'd30 - r_b_len));
            end
        end
    end

    // one root bit per step, test bit walks down by two places
    always_comb begin
        logic [61:0] pn, pr, bt;
        logic [62:0] t;
        for (int k = 0; k < SQ_STEPS; k++) begin
            pn = (k == 0) ? r_e_sum : r_s_n[(k == 0) ? 0 : k - 1];
            pr = (k == 0) ? 62'd0 : r_s_r[(k == 0) ? 0 : k - 1];
            bt = 62'd1 << (60 - 2 * k);
            t  = {1'b0, pr} + {1'b0, bt};
            if ({1'b0, pn} >= t) begin
                n_s_n[k] = pn - t[61:0];
                n_s_r[k] = (pr >> 1) + bt;
            end else begin
                n_s_n[k] = pn;
                n_s_r[k] = pr >> 1;
            end
        end
    end

    // one quotient bit per step, MSB first
    always_comb begin
        logic [2:0][61:0] prem;
        logic [2:0][31:0] pq;
        logic [30:0]      pden;
        logic [62:0]      trial;
        for (int j = 0; j < DIV_STEPS; j++) begin
            prem = (j == 0) ? r_p_rem : r_q_rem[(j == 0) ? 0 : j - 1];
            pq   = (j == 0) ? '0 : r_q_q[(j == 0) ? 0 : j - 1];
            pden = (j == 0) ? r_p_den : r_q_den[(j == 0) ? 0 : j - 1];
            trial = {32'd0, pden} << (DIV_STEPS - 1 - j);
            n_q_rem[j] = prem;
            n_q_q[j]   = pq;
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, prem[i]} >= trial) begin
                    n_q_rem[j][i] = prem[i] - trial[61:0];
                    n_q_q[j][i][DIV_STEPS - 1 - j] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic [31:0] q;
        t_carry c;
        c = r_q_c[DIV_STEPS - 1];
        for (int i = 0; i < 3; i++) begin
            q = r_q_q[DIV_STEPS - 1][i];
            if (q > 32'h4000_0000) q = 32'h4000_0000;
            if (c.zero) begin
                n_o_unit[i] = 32'd0;
            end else if (c.neg[i]) begin
                n_o_unit[i] = ~q + 32'd1;
            end else begin
                n_o_unit[i] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++) r_s_v[k] <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++) r_q_v[j] <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_s_v[0] <= r_e_v;
            for (int k = 1; k < SQ_STEPS; k++) r_s_v[k] <= r_s_v[k - 1];
            r_p_v <= r_s_v[SQ_STEPS - 1];
            r_q_v[0] <= r_p_v;
            for (int j = 1; j < DIV_STEPS; j++) r_q_v[j] <= r_q_v[j - 1];
            r_o_v <= r_q_v[DIV_STEPS - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= {i_vec[2][63], i_vec[1][63], i_vec[0][63]};
            r_a_or   <= n_a_mag[0] | n_a_mag[1] | n_a_mag[2];
            r_a_side <= i_side;

            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_len  <= bitlen(r_a_or);
            r_b_zero <= (r_a_or == 64'd0);
            r_b_side <= r_a_side;

            r_c_c <= n_c_c;

            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= 60'(r_c_c.m[i]) * 60'(r_c_c.m[i]);
            end
            r_d_c <= r_c_c;

            r_e_sum <= 62'(r_d_sq[0]) + 62'(r_d_sq[1]) + 62'(r_d_sq[2]);
            r_e_c   <= r_d_c;

            for (int k = 0; k < SQ_STEPS; k++) begin
                r_s_n[k] <= n_s_n[k];
                r_s_r[k] <= n_s_r[k];
            end
            r_s_c[0] <= r_e_c;
            for (int k = 1; k < SQ_STEPS; k++) r_s_c[k] <= r_s_c[k - 1];

            // numerator m * 2^30 + len / 2
            for (int i = 0; i < 3; i++) begin
                r_p_rem[i] <= {2'b00, r_s_c[SQ_STEPS - 1].m[i], 30'd0}
                            + {32'd0, r_s_r[SQ_STEPS - 1][30:1]};
            end
            r_p_den <= r_s_r[SQ_STEPS - 1][30:0];
            r_p_c   <= r_s_c[SQ_STEPS - 1];

            for (int j = 0; j < DIV_STEPS; j++) begin
                r_q_rem[j] <= n_q_rem[j];
                r_q_q[j]   <= n_q_q[j];
            end
            r_q_den[0] <= r_p_den;
            r_q_c[0]   <= r_p_c;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_q_den[j] <= r_q_den[j - 1];
                r_q_c[j]   <= r_q_c[j - 1];
            end

            r_o_unit <= n_o_unit;
            r_o_zero <= r_q_c[DIV_STEPS - 1].zero;
            r_o_side <= r_q_c[DIV_STEPS - 1].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_unit  = r_o_unit;
    assign o_zero  = r_o_zero;
    assign o_side  = r_o_side;

endmodule

/* sv/lav_tail.sv */
// Up axis from x cross z, then the three row translations.
module lav_tail (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  lav_pkg::t_v32  i_x,
    input  logic           i_zero,
    input  lav_pkg::t_side i_side,
    output logic           o_valid,
    output lav_pkg::t_rows o_rows
);
    import lav_pkg::*;

    logic                     r_1_v, r_2_v, r_3_v, r_4_v, r_5_v;
    t_v32                     r_1_x, r_1_z, r_1_eye;
    logic                     r_1_dg;
    logic signed [63:0]       r_1_p [6];
    logic signed [63:0]       n_1_p [6];
    t_v32                     r_2_x, r_2_y, r_2_z, r_2_eye, n_2_y;
    logic                     r_2_dg;
    logic signed [63:0]       r_3_p [9];
    logic signed [63:0]       n_3_p [9];
    t_v32                     r_3_x, r_3_y, r_3_z;
    logic                     r_3_dg;
    logic signed [63:0]       r_4_s [3];
    t_v32                     r_4_x, r_4_y, r_4_z;
    logic                     r_4_dg;
    t_rows                    r_5_rows, n_5_rows;

    always_comb begin
        logic signed [63:0] xa [3];
        logic signed [63:0] za [3];
        for (int i = 0; i < 3; i++) begin
            xa[i] = $signed(i_x[i]);
            za[i] = $signed(i_side.vec[i]);
        end
        n_1_p[0] = xa[1] * za[2];
        n_1_p[1] = xa[2] * za[1];
        n_1_p[2] = xa[2] * za[0];
        n_1_p[3] = xa[0] * za[2];
        n_1_p[4] = xa[0] * za[1];
        n_1_p[5] = xa[1] * za[0];
    end

    always_comb begin
        n_2_y[0] = clamp_axis(rnd30(r_1_p[0] - r_1_p[1]));
        n_2_y[1] = clamp_axis(rnd30(r_1_p[2] - r_1_p[3]));
        n_2_y[2] = clamp_axis(rnd30(r_1_p[4] - r_1_p[5]));
    end

    always_comb begin
        logic signed [63:0] e, ax, ay, az;
        for (int i = 0; i < 3; i++) begin
            e  = $signed(r_2_eye[i]);
            ax = $signed(r_2_x[i]);
            ay = $signed(r_2_y[i]);
            az = $signed(r_2_z[i]);
            n_3_p[i]     = ax * e;
            n_3_p[3 + i] = ay * e;
            n_3_p[6 + i] = az * e;
        end
    end

    always_comb begin
        n_5_rows.axis[0] = r_4_x;
        n_5_rows.axis[1] = r_4_y;
        for (int i = 0; i < 3; i++) begin
            n_5_rows.axis[2][i] = ~r_4_z[i] + 32'd1;
        end
        n_5_rows.off[0] = sat32(-rnd30(r_4_s[0]));
        n_5_rows.off[1] = sat32(-rnd30(r_4_s[1]));
        n_5_rows.off[2] = sat32(rnd30(r_4_s[2]));
        n_5_rows.degen  = r_4_dg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_v <= 1'b0;
            r_2_v <= 1'b0;
            r_3_v <= 1'b0;
            r_4_v <= 1'b0;
            r_5_v <= 1'b0;
        end else if (i_en) begin
            r_1_v <= i_valid;
            r_2_v <= r_1_v;
            r_3_v <= r_2_v;
            r_4_v <= r_3_v;
            r_5_v <= r_4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_1_p   <= n_1_p;
            r_1_x   <= i_x;
            r_1_z   <= i_side.vec;
            r_1_eye <= i_side.eye;
            r_1_dg  <= i_side.degen | i_zero;

            r_2_x   <= r_1_x;
            r_2_y   <= n_2_y;
            r_2_z   <= r_1_z;
            r_2_eye <= r_1_eye;
            r_2_dg  <= r_1_dg;

            r_3_p  <= n_3_p;
            r_3_x  <= r_2_x;
            r_3_y  <= r_2_y;
            r_3_z  <= r_2_z;
            r_3_dg <= r_2_dg;

            for (int r = 0; r < 3; r++) begin
                r_4_s[r] <= r_3_p[3 * r] + r_3_p[3 * r + 1] + r_3_p[3 * r + 2];
            end
            r_4_x  <= r_3_x;
            r_4_y  <= r_3_y;
            r_4_z  <= r_3_z;
            r_4_dg <= r_3_dg;

            r_5_rows <= n_5_rows;
        end
    end

    assign o_valid = r_5_v;
    assign o_rows  = r_5_rows;

endmodule

/* sv/look_at_view_matrix_top.sv */
// Look-at view matrix: input stage, two normalizers, cross product, tail, row emitter.
// Rows are sent one per cycle while m_axis_tready is high, three row beats per item.
// The whole pipeline advances together; it holds while the emitter still has rows to send.
// Reset (i_rst_n low, synchronous) clears all valid bits; no data is lost or repeated on stalls.
module look_at_view_matrix_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // axis_a, axis_b, axis_c, offset
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // row_index[1:0], degenerate[2]
    output logic [2:0]   m_axis_tuser
);
    import lav_pkg::*;

    logic                en;
    logic                r_in_v;
    logic [287:0]        r_in;
    t_v64                w_d;
    t_side               w_side1;
    logic                w_n1_v, w_n1_zero;
    t_v32                w_n1_unit;
    t_side               w_n1_side;
    logic                r_c1_v, r_c2_v;
    logic signed [63:0]  r_c1_p [6];
    logic signed [63:0]  n_c1_p [6];
    t_side               r_c1_side, r_c2_side;
    t_v64                r_c2_c;
    logic                w_n2_v, w_n2_zero;
    t_v32                w_n2_unit;
    t_side               w_n2_side;
    logic                w_t_v;
    t_rows               w_t_rows;
    logic                r_hv;
    logic [1:0]          r_row;
    t_rows               r_hold;

    assign en = !r_hv || (m_axis_tready && (r_row == ROW_FWD));
    assign s_axis_tready = en;

    always_comb begin
        logic signed [63:0] e, t;
        for (int i = 0; i < 3; i++) begin
            e = $signed(r_in[32 * i +: 32]);
            t = $signed(r_in[96 + 32 * i +: 32]);
            w_d[i] = t - e;
            w_side1.eye[i] = r_in[32 * i +: 32];
            w_side1.vec[i] = r_in[192 + 32 * i +: 32];
        end
        w_side1.degen = 1'b0;
    end

    lav_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_vec   (w_d),
        .i_side  (w_side1),
        .o_valid (w_n1_v),
        .o_unit  (w_n1_unit),
        .o_zero  (w_n1_zero),
        .o_side  (w_n1_side)
    );

    // z cross up
    always_comb begin
        logic signed [63:0] za [3];
        logic signed [63:0] ua [3];
        for (int i = 0; i < 3; i++) begin
            za[i] = $signed(w_n1_unit[i]);
            ua[i] = $signed(w_n1_side.vec[i]);
        end
        n_c1_p[0] = za[1] * ua[2];
        n_c1_p[1] = za[2] * ua[1];
        n_c1_p[2] = za[2] * ua[0];
        n_c1_p[3] = za[0] * ua[2];
        n_c1_p[4] = za[0] * ua[1];
        n_c1_p[5] = za[1] * ua[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (en) begin
            r_in_v <= s_axis_tvalid;
            r_c1_v <= w_n1_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= s_axis_tdata;
            r_c1_p <= n_c1_p;
            r_c1_side.eye   <= w_n1_side.eye;
            r_c1_side.vec   <= w_n1_unit;
            r_c1_side.degen <= w_n1_zero;
            r_c2_c[0] <= r_c1_p[0] - r_c1_p[1];
            r_c2_c[1] <= r_c1_p[2] - r_c1_p[3];
            r_c2_c[2] <= r_c1_p[4] - r_c1_p[5];
            r_c2_side <= r_c1_side;
        end
    end

    lav_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c2_v),
        .i_vec   (r_c2_c),
        .i_side  (r_c2_side),
        .o_valid (w_n2_v),
        .o_unit  (w_n2_unit),
        .o_zero  (w_n2_zero),
        .o_side  (w_n2_side)
    );

    lav_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_n2_v),
        .i_x     (w_n2_unit),
        .i_zero  (w_n2_zero),
        .i_side  (w_n2_side),
        .o_valid (w_t_v),
        .o_rows  (w_t_rows)
    );

    // hold one item and send its three rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_row <= ROW_RIGHT;
        end else if (en) begin
            r_hv  <= w_t_v;
            r_row <= ROW_RIGHT;
        end else if (m_axis_tready) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hold <= w_t_rows;
        end
    end

    always_comb begin
        case (r_row)
            ROW_RIGHT: m_axis_tdata = {r_hold.off[0], r_hold.axis[0]};
            ROW_UP:    m_axis_tdata = {r_hold.off[1], r_hold.axis[1]};
            ROW_FWD:   m_axis_tdata = {r_hold.off[2], r_hold.axis[2]};
            default:   m_axis_tdata = '0;
        endcase
    end

    assign m_axis_tvalid = r_hv;
    assign m_axis_tlast  = (r_row == ROW_FWD);
    assign m_axis_tuser  = {r_hold.degen, r_row};

endmodule
